/* design/urx_pkg.sv */
package urx_pkg;

    // Default receive FIFO depth.
    localparam int unsigned FIFO_DEPTH_DEF = 8;

    // Field widths of the bus and line interface.
    localparam int unsigned OP_W     = 2;
    localparam int unsigned OFFSET_W = 10;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CTRL_W   = 7;
    localparam int unsigned STAT_W   = 4;

    // Kind of item arriving on the input channel.
    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2,
        OP_BREAK = 2'd3
    } t_op;

    // Register word indexes.
    localparam logic [OFFSET_W-1:0] REG_DATA   = 10'd0;
    localparam logic [OFFSET_W-1:0] REG_STATUS = 10'd1;
    localparam logic [OFFSET_W-1:0] REG_CTRL   = 10'd2;

    // Control register bit positions.
    localparam int unsigned CTL_RX_ON       = 0;
    localparam int unsigned CTL_TX_ON       = 1;
    localparam int unsigned CTL_RX_IRQ_ON   = 2;
    localparam int unsigned CTL_OVR_IRQ_ON  = 3;
    localparam int unsigned CTL_CLR_ERR     = 4;
    localparam int unsigned CTL_CLR_IRQ     = 5;
    localparam int unsigned CTL_CLR_ERR_IRQ = 6;

    // Status register bit positions.
    localparam int unsigned ST_AVAIL    = 0;
    localparam int unsigned ST_OVERRUN  = 1;
    localparam int unsigned ST_RX_PEND  = 2;
    localparam int unsigned ST_OVR_PEND = 3;

endpackage

/* design/urx_ram.sv */
module urx_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/uart_rx_fifo_status_irq_core.sv */
// Channel  Direction  Handshake                 Payload
// input    in         i_in_valid / o_in_ready   i_operation, i_offset, i_write_data, i_rx_byte
// output   out        o_out_valid / i_out_ready o_read_data, o_tx_valid, o_tx_byte,
//                                               o_irq_rx, o_irq_error, o_irq_combined,
//                                               o_bad_offset
//
// Each item's result is registered at the edge of its transfer and shown in the next
// cycle, so one item per cycle is sustained while the output side is ready.
// A popped byte comes straight from the registered read port of the FIFO RAM.
// Reset clears pointers, fill count, status, control and interrupt levels; the FIFO RAM
// itself is not cleared and needs no clearing pass.
// The input is stalled only while a result waits and the output side is not ready.
module uart_rx_fifo_status_irq_core #(
    parameter int unsigned FIFO_DEPTH = urx_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [urx_pkg::OP_W-1:0]      i_operation,
    input  logic [urx_pkg::OFFSET_W-1:0]  i_offset,
    input  logic [urx_pkg::DATA_W-1:0]    i_write_data,
    input  logic [urx_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [urx_pkg::DATA_W-1:0]    o_read_data,
    output logic                          o_tx_valid,
    output logic [urx_pkg::BYTE_W-1:0]    o_tx_byte,
    output logic                          o_irq_rx,
    output logic                          o_irq_error,
    output logic                          o_irq_combined,
    output logic                          o_bad_offset
);

    import urx_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // Block state.
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [STAT_W-1:0] r_status, n_status;
    logic [CTRL_W-1:0] r_ctrl, n_ctrl;
    logic [1:0]        r_irq, n_irq;

    // Result register.
    logic              r_out_valid;
    logic [DATA_W-1:0] r_read_data, n_read_data;
    logic              r_pop_sel, n_pop_sel;
    logic              r_tx_valid, n_tx_valid;
    logic [BYTE_W-1:0] r_tx_byte, n_tx_byte;
    logic              r_bad, n_bad;

    logic              in_xfer;
    logic              push;
    logic [BYTE_W-1:0] push_byte;
    logic [BYTE_W-1:0] ram_q;
    t_op               op;

    assign op         = t_op'(i_operation);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Next state and result for the item in transfer.
    always_comb begin
        logic do_refresh;
        logic line_put;

        do_refresh  = 1'b0;
        line_put    = 1'b0;
        push        = 1'b0;
        push_byte   = '0;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_count     = r_count;
        n_status    = r_status;
        n_ctrl      = r_ctrl;
        n_irq       = r_irq;
        n_read_data = '0;
        n_pop_sel   = 1'b0;
        n_tx_valid  = 1'b0;
        n_tx_byte   = '0;
        n_bad       = 1'b0;

        case (op)
            OP_READ: begin
                if (i_offset == REG_DATA) begin
                    // Pop when something is held; the byte comes from the RAM port.
                    if (r_count != '0) begin
                        n_pop_sel = 1'b1;
                        n_rd_ptr  = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                        n_count   = r_count - 1'b1;
                    end
                    do_refresh = 1'b1;
                end else if (i_offset == REG_STATUS) begin
                    n_read_data = DATA_W'(r_status);
                end else if (i_offset == REG_CTRL) begin
                    n_read_data = DATA_W'(r_ctrl);
                end else begin
                    n_bad = 1'b1;
                end
            end
            OP_WRITE: begin
                if (i_offset == REG_DATA) begin
                    if (r_ctrl[CTL_TX_ON]) begin
                        n_tx_valid = 1'b1;
                        n_tx_byte  = i_write_data[BYTE_W-1:0];
                    end
                end else if (i_offset == REG_STATUS) begin
                    // A status write takes effect without a refresh.
                    n_status = i_write_data[STAT_W-1:0];
                end else if (i_offset == REG_CTRL) begin
                    n_ctrl     = i_write_data[CTRL_W-1:0];
                    do_refresh = 1'b1;
                end else begin
                    n_bad = 1'b1;
                end
            end
            OP_RX: begin
                line_put   = 1'b1;
                push_byte  = i_rx_byte;
                do_refresh = 1'b1;
            end
            OP_BREAK: begin
                line_put   = 1'b1;
                do_refresh = 1'b1;
            end
            default: begin
                n_bad = 1'b0;
            end
        endcase

        // While receive is on, a line byte enters the FIFO, or sets overrun when the FIFO is full.
        if (line_put && r_ctrl[CTL_RX_ON]) begin
            if (r_count == CNT_FULL) begin
                n_status[ST_OVERRUN] = 1'b1;
            end else begin
                push     = 1'b1;
                n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                n_count  = r_count + 1'b1;
            end
        end

        // Refresh: self-clearing clear bits, then sticky pending bits and levels.
        if (do_refresh) begin
            if (n_ctrl[CTL_CLR_ERR]) begin
                n_status[ST_OVERRUN] = 1'b0;
            end
            if (n_ctrl[CTL_CLR_IRQ]) begin
                n_status[ST_RX_PEND] = 1'b0;
            end
            if (n_ctrl[CTL_CLR_ERR_IRQ]) begin
                n_status[ST_OVR_PEND] = 1'b0;
            end
            n_ctrl[CTL_CLR_ERR]     = 1'b0;
            n_ctrl[CTL_CLR_IRQ]     = 1'b0;
            n_ctrl[CTL_CLR_ERR_IRQ] = 1'b0;

            n_status[ST_AVAIL] = (n_count != '0);
            if (n_status[ST_AVAIL] && n_ctrl[CTL_RX_IRQ_ON]) begin
                n_status[ST_RX_PEND] = 1'b1;
            end
            if (n_status[ST_OVERRUN] && n_ctrl[CTL_OVR_IRQ_ON]) begin
                n_status[ST_OVR_PEND] = 1'b1;
            end
            n_irq = {n_status[ST_OVR_PEND], n_status[ST_RX_PEND]};
        end
    end

    // Receive FIFO storage.
    urx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && push),
        .i_waddr (r_wr_ptr),
        .i_wdata (push_byte),
        .i_re    (in_xfer && n_pop_sel),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    // Control state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_status    <= '0;
            r_ctrl      <= '0;
            r_irq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_rd_ptr <= n_rd_ptr;
                r_wr_ptr <= n_wr_ptr;
                r_count  <= n_count;
                r_status <= n_status;
                r_ctrl   <= n_ctrl;
                r_irq    <= n_irq;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded on each input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_read_data <= n_read_data;
            r_pop_sel   <= n_pop_sel;
            r_tx_valid  <= n_tx_valid;
            r_tx_byte   <= n_tx_byte;
            r_bad       <= n_bad;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_pop_sel ? DATA_W'(ram_q) : r_read_data;
    assign o_tx_valid     = r_tx_valid;
    assign o_tx_byte      = r_tx_byte;
    assign o_irq_rx       = r_irq[0];
    assign o_irq_error    = r_irq[1];
    assign o_irq_combined = |r_irq;
    assign o_bad_offset   = r_bad;

endmodule

/* sim/tb_uart_rx_fifo_status_irq_core.sv */
module tb_uart_rx_fifo_status_irq_core;
    import urx_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 250000;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned PRINT_CAP = 100;

    // One result of the block, field by field.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              irq_rx;
        logic              irq_error;
        logic              irq_combined;
        logic              bad_offset;
    } t_reply;

    // Register block mirror and the queue of replies it has computed.
    class uart_reply_board;
        logic [BYTE_W-1:0] rx_bytes [FIFO_DEPTH_DEF];
        int unsigned       head;
        int unsigned       tail;
        int unsigned       fill;
        logic [STAT_W-1:0] status;
        logic [CTRL_W-1:0] ctrl;
        logic [1:0]        irq;
        t_reply            replies_due[$];
        int unsigned       n_mismatch;

        function new();
            head = 0;
            tail = 0;
            fill = 0;
            status = '0;
            ctrl = '0;
            irq = '0;
            n_mismatch = 0;
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction

        // Self-clearing clears, then the sticky status and interrupt levels.
        function void refresh_status();
            if (ctrl[CTL_CLR_ERR]) status[ST_OVERRUN] = 1'b0;
            if (ctrl[CTL_CLR_IRQ]) status[ST_RX_PEND] = 1'b0;
            if (ctrl[CTL_CLR_ERR_IRQ]) status[ST_OVR_PEND] = 1'b0;
            ctrl[CTL_CLR_ERR] = 1'b0;
            ctrl[CTL_CLR_IRQ] = 1'b0;
            ctrl[CTL_CLR_ERR_IRQ] = 1'b0;
            status[ST_AVAIL] = (fill != 0);
            if (fill != 0 && ctrl[CTL_RX_IRQ_ON]) status[ST_RX_PEND] = 1'b1;
            if (status[ST_OVERRUN] && ctrl[CTL_OVR_IRQ_ON]) status[ST_OVR_PEND] = 1'b1;
            irq = {status[ST_OVR_PEND], status[ST_RX_PEND]};
        endfunction

        // A byte from the line: dropped when receive is off, overrun when full.
        function void push_line_byte(logic [BYTE_W-1:0] b);
            if (!ctrl[CTL_RX_ON]) return;
            if (fill >= FIFO_DEPTH_DEF) begin
                status[ST_OVERRUN] = 1'b1;
                return;
            end
            rx_bytes[tail] = b;
            tail = (tail + 1) % FIFO_DEPTH_DEF;
            fill++;
        endfunction

        function logic [DATA_W-1:0] pop_rx_byte();
            logic [DATA_W-1:0] v;
            if (fill == 0) return '0;
            v = {{(DATA_W-BYTE_W){1'b0}}, rx_bytes[head]};
            head = (head + 1) % FIFO_DEPTH_DEF;
            fill--;
            return v;
        endfunction

        // Work out the reply of one accepted request and queue it.
        function void note_request(t_op op, logic [OFFSET_W-1:0] off,
                                   logic [DATA_W-1:0] wd, logic [BYTE_W-1:0] rb);
            t_reply r;
            r = '0;
            case (op)
                OP_READ: begin
                    if (off == REG_DATA) begin
                        r.read_data = pop_rx_byte();
                        refresh_status();
                    end else if (off == REG_STATUS) begin
                        r.read_data = {{(DATA_W-STAT_W){1'b0}}, status};
                    end else if (off == REG_CTRL) begin
                        r.read_data = {{(DATA_W-CTRL_W){1'b0}}, ctrl};
                    end else begin
                        r.bad_offset = 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (off == REG_DATA) begin
                        if (ctrl[CTL_TX_ON]) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = wd[BYTE_W-1:0];
                        end
                    end else if (off == REG_STATUS) begin
                        // No refresh here: the interrupt levels keep their old value.
                        status = wd[STAT_W-1:0];
                    end else if (off == REG_CTRL) begin
                        ctrl = wd[CTRL_W-1:0];
                        refresh_status();
                    end else begin
                        r.bad_offset = 1'b1;
                    end
                end
                OP_RX: begin
                    push_line_byte(rb);
                    refresh_status();
                end
                default: begin
                    push_line_byte('0);
                    refresh_status();
                end
            endcase
            r.irq_rx = irq[0];
            r.irq_error = irq[1];
            r.irq_combined = |irq;
            replies_due.push_back(r);
        endfunction

        task report_mismatch(string msg);
            n_mismatch++;
            if (n_mismatch <= PRINT_CAP) $display("mismatch %0d: %s", n_mismatch, msg);
        endtask

        task compare_field(string name, logic [DATA_W-1:0] got,
                           logic [DATA_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        endtask

        // Compare one transferred result with the oldest reply due.
        task check_reply(t_reply got);
            t_reply want;
            if (replies_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = replies_due.pop_front();
            compare_field("read_data", got.read_data, want.read_data);
            compare_field("tx_valid", DATA_W'(got.tx_valid), DATA_W'(want.tx_valid));
            compare_field("tx_byte", DATA_W'(got.tx_byte), DATA_W'(want.tx_byte));
            compare_field("irq_rx", DATA_W'(got.irq_rx), DATA_W'(want.irq_rx));
            compare_field("irq_error", DATA_W'(got.irq_error), DATA_W'(want.irq_error));
            compare_field("irq_combined", DATA_W'(got.irq_combined),
                          DATA_W'(want.irq_combined));
            compare_field("bad_offset", DATA_W'(got.bad_offset), DATA_W'(want.bad_offset));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_operation;
    logic [OFFSET_W-1:0] i_offset;
    logic [DATA_W-1:0]   i_write_data;
    logic [BYTE_W-1:0]   i_rx_byte;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [DATA_W-1:0]   o_read_data;
    logic                o_tx_valid;
    logic [BYTE_W-1:0]   o_tx_byte;
    logic                o_irq_rx;
    logic                o_irq_error;
    logic                o_irq_combined;
    logic                o_bad_offset;

    uart_reply_board board = new();
    int unsigned     n_cycles = 0;
    bit              send_calm = 1'b0;
    bit              take_calm = 1'b0;

    uart_rx_fifo_status_irq_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_offset       (i_offset),
        .i_write_data   (i_write_data),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_irq_rx       (o_irq_rx),
        .o_irq_error    (o_irq_error),
        .o_irq_combined (o_irq_combined),
        .o_bad_offset   (o_bad_offset)
    );

    // Clock with a period of 12.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Wait before the next transfer; now and then a side runs with no gaps at all.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // Offer one request and hold it until its transfer; called at a rising edge.
    task automatic send_item(input t_op op, input logic [OFFSET_W-1:0] off,
                             input logic [DATA_W-1:0] wd, input logic [BYTE_W-1:0] rb);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_offset <= off;
        i_write_data <= wd;
        i_rx_byte <= rb;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        board.note_request(op, off, wd, rb);
    endtask

    // Directed walk: reset state, bad offsets, transmit, fill to overrun, clears.
    task automatic run_directed();
        send_item(OP_READ, REG_STATUS, $urandom, BYTE_W'($urandom));
        send_item(OP_READ, REG_CTRL, $urandom, BYTE_W'($urandom));
        send_item(OP_READ, REG_DATA, $urandom, BYTE_W'($urandom));
        send_item(OP_WRITE, REG_DATA, 32'hFFFF_FFFF, 8'h00);
        send_item(OP_RX, REG_DATA, 32'h0, 8'hFF);
        send_item(OP_BREAK, 10'h3FF, 32'h0, 8'hFF);
        send_item(OP_READ, 10'd3, 32'h0, 8'h00);
        send_item(OP_WRITE, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);
        send_item(OP_WRITE, REG_CTRL, 32'hFFFF_FFFF, 8'h00);
        send_item(OP_WRITE, REG_DATA, 32'h0000_00A5, 8'h00);
        send_item(OP_RX, 10'h3FF, 32'h0, 8'hFF);
        send_item(OP_RX, REG_DATA, 32'hFFFF_FFFF, 8'h00);
        send_item(OP_BREAK, REG_DATA, 32'h0, 8'h77);
        // Six more bytes: the last one finds the receive FIFO full.
        for (int k = 0; k < 6; k++) send_item(OP_RX, REG_DATA, 32'h0, 8'h5A ^ 8'(k));
        send_item(OP_READ, REG_STATUS, 32'h0, 8'h00);
        send_item(OP_READ, REG_DATA, 32'h0, 8'h00);
        send_item(OP_READ, REG_DATA, 32'h0, 8'h00);
        send_item(OP_WRITE, REG_STATUS, 32'hFFFF_FFF0, 8'h00);
        send_item(OP_READ, REG_STATUS, 32'h0, 8'h00);
        send_item(OP_WRITE, REG_STATUS, 32'h0000_000F, 8'h00);
        send_item(OP_WRITE, REG_CTRL, 32'h0000_0070, 8'h00);
        send_item(OP_WRITE, REG_CTRL, 32'h0000_0000, 8'h00);
    endtask

    // Random traffic that swings between filling and draining the FIFO.
    task automatic run_random(input int unsigned n_items);
        t_op                 op;
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   wd;
        int unsigned         pick;
        bit                  fill_phase = 1'b1;
        for (int unsigned k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 63) == 0) fill_phase = !fill_phase;
            pick = $urandom_range(0, 99);
            wd = $urandom;
            off = ($urandom_range(0, 6) == 0) ? OFFSET_W'($urandom)
                                               : OFFSET_W'($urandom_range(0, 2));
            if (pick < (fill_phase ? 45 : 15)) begin
                op = ($urandom_range(0, 7) == 0) ? OP_BREAK : OP_RX;
            end else if (pick < 70) begin
                op = OP_READ;
                if ($urandom_range(0, 1) == 1) off = REG_DATA;
            end else begin
                op = OP_WRITE;
                // Mostly keep receive on so bytes reach the FIFO.
                if (off == REG_CTRL && $urandom_range(0, 9) != 0) wd[CTL_RX_ON] = 1'b1;
            end
            send_item(op, off, wd, BYTE_W'($urandom));
        end
    endtask

    // Result side: random stalls, then take one transfer and check it.
    initial begin
        t_reply got;
        int     stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_wait(take_calm);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.read_data = o_read_data;
            got.tx_valid = o_tx_valid;
            got.tx_byte = o_tx_byte;
            got.irq_rx = o_irq_rx;
            got.irq_error = o_irq_error;
            got.irq_combined = o_irq_combined;
            got.bad_offset = o_bad_offset;
            board.check_reply(got);
        end
    end

    // Request side: reset, directed part, random part, then drain.
    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_operation <= OP_READ;
        i_offset <= '0;
        i_write_data <= '0;
        i_rx_byte <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(RANDOM_ITEMS);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.n_mismatch == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
